// ===== rtl/core/srvb_pkg.sv =====
// shared constants, types and helpers of the stereo schroeder reverb
`default_nettype none
package srvb_pkg;

  localparam int SAMPLE_RATE = 48000;
  localparam int SB          = 24;
  localparam int COMB_MAX    = 8;
  localparam int AP_MAX      = 4;
  localparam int LINE_W      = 3;
  localparam int AP_LINE_W   = 2;

  // line lengths in samples, tunings in units of 0.1 ms
  localparam int unsigned COMB_LEN [COMB_MAX] = '{
    SAMPLE_RATE * 298 / 10000, SAMPLE_RATE * 333 / 10000,
    SAMPLE_RATE * 371 / 10000, SAMPLE_RATE * 411 / 10000,
    SAMPLE_RATE * 447 / 10000, SAMPLE_RATE * 479 / 10000,
    SAMPLE_RATE * 509 / 10000, SAMPLE_RATE * 559 / 10000};
  localparam int unsigned COMB_BASE [COMB_MAX] = '{
    0,
    COMB_LEN[0],
    COMB_LEN[0] + COMB_LEN[1],
    COMB_LEN[0] + COMB_LEN[1] + COMB_LEN[2],
    COMB_LEN[0] + COMB_LEN[1] + COMB_LEN[2] + COMB_LEN[3],
    COMB_LEN[0] + COMB_LEN[1] + COMB_LEN[2] + COMB_LEN[3] + COMB_LEN[4],
    COMB_LEN[0] + COMB_LEN[1] + COMB_LEN[2] + COMB_LEN[3] + COMB_LEN[4] + COMB_LEN[5],
    COMB_LEN[0] + COMB_LEN[1] + COMB_LEN[2] + COMB_LEN[3] + COMB_LEN[4] + COMB_LEN[5]
      + COMB_LEN[6]};
  localparam int unsigned COMB_TOTAL = COMB_BASE[7] + COMB_LEN[7];

  localparam int unsigned AP_LEN [AP_MAX] = '{
    SAMPLE_RATE * 50 / 10000, SAMPLE_RATE * 17 / 10000,
    SAMPLE_RATE * 13 / 10000, SAMPLE_RATE * 11 / 10000};
  localparam int unsigned AP_BASE [AP_MAX] = '{
    0, AP_LEN[0], AP_LEN[0] + AP_LEN[1], AP_LEN[0] + AP_LEN[1] + AP_LEN[2]};
  localparam int unsigned AP_TOTAL = AP_BASE[3] + AP_LEN[3];

  localparam int CAW = $clog2(COMB_TOTAL);
  localparam int AAW = $clog2(AP_TOTAL);
  localparam int CPW = $clog2(COMB_LEN[7]);
  localparam int APW = $clog2(AP_LEN[0]);

  localparam int WET_W  = SB + 4;
  localparam int O_W    = 32;
  localparam int GAIN_W = 17;
  localparam int FB_W   = 16;
  localparam int IDX_W  = 8;

  localparam logic [GAIN_W-1:0] UNITY       = GAIN_W'(65536);
  localparam logic [GAIN_W-1:0] ROOM_RESET  = GAIN_W'(32768);
  localparam logic [GAIN_W-1:0] WET_RESET   = GAIN_W'(21627);
  localparam logic [GAIN_W-1:0] DRY_RESET   = GAIN_W'(45875);
  localparam logic [GAIN_W-1:0] WIDTH_RESET = GAIN_W'(65536);
  localparam logic [FB_W-1:0]   FB_RESET    = FB_W'(32768 * 9 / 10);

  // floor(y / 10) for y < 2^20 as (y * ceil(2^23 / 10)) >> 23
  localparam int DIV10_SH = 23;
  localparam logic [19:0] DIV10_MUL = 20'((2 ** DIV10_SH + 9) / 10);

  localparam logic [IDX_W-1:0] REG_ROOM  = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_WET   = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_DRY   = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_WIDTH = IDX_W'(3);

  typedef enum logic [3:0] {
    ST_IDLE, ST_C_RD, ST_C_MUL, ST_C_WR, ST_A_RD, ST_A_WR,
    ST_G_MUL, ST_G_MIX, ST_W_MUL, ST_W_FIN, ST_OUT
  } srvb_state_t;

  typedef struct packed {
    logic              load_in;
    logic              comb_rd;
    logic              comb_mul;
    logic              comb_wr;
    logic              ap_rd;
    logic              ap_wr;
    logic              gain;
    logic              mix;
    logic              wid_mul;
    logic              wid_fin;
    logic              out_load;
    logic              ch;
    logic [LINE_W-1:0] line;
  } srvb_cmd_t;

  typedef struct packed {
    logic out_free;
    logic width_bypass;
  } srvb_stat_t;

  function automatic logic signed [SB-1:0] sat_smp(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (SB - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) return SB'(hi);
    else if (v < lo) return SB'(lo);
    else return SB'(v);
  endfunction

  function automatic logic [GAIN_W-1:0] clamp_gain(input logic [GAIN_W-1:0] g);
    return (g > UNITY) ? UNITY : g;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/srvb_ctrl.sv =====
// sequencer that walks the comb, allpass, gain and width steps of one item
`default_nettype none
module srvb_ctrl #(
  parameter int COMB_LINES    = srvb_pkg::COMB_MAX,
  parameter int ALLPASS_LINES = srvb_pkg::AP_MAX
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire srvb_pkg::srvb_stat_t stat,
  output srvb_pkg::srvb_cmd_t      cmd
);

  localparam logic [srvb_pkg::LINE_W-1:0] COMB_LAST = srvb_pkg::LINE_W'(COMB_LINES - 1);
  localparam logic [srvb_pkg::LINE_W-1:0] AP_LAST   = srvb_pkg::LINE_W'(ALLPASS_LINES - 1);

  srvb_pkg::srvb_state_t state, state_next;
  logic [srvb_pkg::LINE_W-1:0] line, line_next;
  logic ch, ch_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srvb_pkg::ST_IDLE;
      line  <= '0;
      ch    <= 1'b0;
    end else begin
      state <= state_next;
      line  <= line_next;
      ch    <= ch_next;
    end
  end

  always_comb begin
    state_next = state;
    line_next  = line;
    ch_next    = ch;
    case (state)
      srvb_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = srvb_pkg::ST_C_RD;
          line_next  = '0;
        end
      end
      srvb_pkg::ST_C_RD:  state_next = srvb_pkg::ST_C_MUL;
      srvb_pkg::ST_C_MUL: state_next = srvb_pkg::ST_C_WR;
      srvb_pkg::ST_C_WR: begin
        if (line == COMB_LAST) begin
          state_next = srvb_pkg::ST_A_RD;
          line_next  = '0;
        end else begin
          state_next = srvb_pkg::ST_C_RD;
          line_next  = line + 1'b1;
        end
      end
      srvb_pkg::ST_A_RD: state_next = srvb_pkg::ST_A_WR;
      srvb_pkg::ST_A_WR: begin
        if (line == AP_LAST) begin
          state_next = srvb_pkg::ST_G_MUL;
          ch_next    = 1'b0;
        end else begin
          state_next = srvb_pkg::ST_A_RD;
          line_next  = line + 1'b1;
        end
      end
      srvb_pkg::ST_G_MUL: state_next = srvb_pkg::ST_G_MIX;
      srvb_pkg::ST_G_MIX: begin
        if (ch) begin
          state_next = stat.width_bypass ? srvb_pkg::ST_OUT : srvb_pkg::ST_W_MUL;
        end else begin
          state_next = srvb_pkg::ST_G_MUL;
          ch_next    = 1'b1;
        end
      end
      srvb_pkg::ST_W_MUL: state_next = srvb_pkg::ST_W_FIN;
      srvb_pkg::ST_W_FIN: state_next = srvb_pkg::ST_OUT;
      srvb_pkg::ST_OUT: begin
        if (stat.out_free) state_next = srvb_pkg::ST_IDLE;
      end
      default: state_next = srvb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.line = line;
    cmd.ch   = ch;
    in_ready = 1'b0;
    case (state)
      srvb_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      srvb_pkg::ST_C_RD:  cmd.comb_rd  = 1'b1;
      srvb_pkg::ST_C_MUL: cmd.comb_mul = 1'b1;
      srvb_pkg::ST_C_WR:  cmd.comb_wr  = 1'b1;
      srvb_pkg::ST_A_RD:  cmd.ap_rd    = 1'b1;
      srvb_pkg::ST_A_WR:  cmd.ap_wr    = 1'b1;
      srvb_pkg::ST_G_MUL: cmd.gain     = 1'b1;
      srvb_pkg::ST_G_MIX: cmd.mix      = 1'b1;
      srvb_pkg::ST_W_MUL: cmd.wid_mul  = 1'b1;
      srvb_pkg::ST_W_FIN: cmd.wid_fin  = 1'b1;
      srvb_pkg::ST_OUT:   cmd.out_load = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/srvb_dp.sv =====
// datapath: delay line memories, pointers, multipliers and output register
`default_nettype none
module srvb_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire srvb_pkg::srvb_cmd_t           cmd,
  output srvb_pkg::srvb_stat_t               stat,
  input  wire logic [2*srvb_pkg::SB-1:0]     in_data,
  input  wire logic [srvb_pkg::FB_W-1:0]     fb,
  input  wire logic [srvb_pkg::GAIN_W-1:0]   wet_gain,
  input  wire logic [srvb_pkg::GAIN_W-1:0]   dry_gain,
  input  wire logic [srvb_pkg::GAIN_W-1:0]   stereo_width,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [2*srvb_pkg::SB-1:0]          out_data
);

  localparam int SB = srvb_pkg::SB;
  localparam int AP_LINE_SEL_W = srvb_pkg::AP_LINE_W;

  logic [2*SB-1:0] comb_mem [srvb_pkg::COMB_TOTAL];
  logic [2*SB-1:0] ap_mem [srvb_pkg::AP_TOTAL];

  logic [srvb_pkg::CPW-1:0] comb_ptr [srvb_pkg::COMB_MAX];
  logic [srvb_pkg::APW-1:0] ap_ptr [srvb_pkg::AP_MAX];
  logic [srvb_pkg::COMB_MAX-1:0] comb_wrap;
  logic [srvb_pkg::AP_MAX-1:0] ap_wrap;

  logic [2*SB-1:0] comb_rdata, ap_rdata;
  logic comb_rvalid, ap_rvalid;

  logic signed [SB-1:0] dry [2];
  logic signed [srvb_pkg::WET_W-1:0] wet [2];
  logic signed [SB+16:0] pc [2];
  logic signed [srvb_pkg::WET_W+17:0] pw;
  logic signed [SB+17:0] pd;
  logic signed [srvb_pkg::O_W-1:0] o [2];
  logic signed [srvb_pkg::O_W:0] msum;
  logic signed [srvb_pkg::O_W+18:0] ws;

  logic [AP_LINE_SEL_W-1:0] ap_line;

  logic [srvb_pkg::CAW-1:0] comb_addr;
  logic [srvb_pkg::AAW-1:0] ap_addr;
  logic signed [SB-1:0] comb_old [2];
  logic signed [SB-1:0] ap_old [2];
  logic signed [SB-1:0] comb_new [2];
  logic signed [SB-1:0] ap_new [2];
  logic signed [srvb_pkg::O_W:0] wdiff;
  logic signed [17:0] fb_s, gw_s, gd_s, w_s;
  logic signed [63:0] mm;

  assign ap_line   = cmd.line[AP_LINE_SEL_W-1:0];
  assign comb_addr = srvb_pkg::CAW'(srvb_pkg::COMB_BASE[cmd.line])
                   + srvb_pkg::CAW'(comb_ptr[cmd.line]);
  assign ap_addr   = srvb_pkg::AAW'(srvb_pkg::AP_BASE[ap_line])
                   + srvb_pkg::AAW'(ap_ptr[ap_line]);

  assign fb_s = $signed({2'b00, fb});
  assign gw_s = $signed({1'b0, wet_gain});
  assign gd_s = $signed({1'b0, dry_gain});
  assign w_s  = $signed({1'b0, stereo_width});
  assign wdiff = (srvb_pkg::O_W + 1)'(o[1]) - (srvb_pkg::O_W + 1)'(o[0]);
  assign mm = 64'(msum) <<< 16;

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      comb_old[c] = comb_rvalid ? $signed(comb_rdata[c*SB +: SB]) : '0;
      ap_old[c]   = ap_rvalid ? $signed(ap_rdata[c*SB +: SB]) : '0;
      comb_new[c] = srvb_pkg::sat_smp(64'(dry[c])
                    + ((64'(pc[c]) + 64'sd32768) >>> 16));
      ap_new[c]   = srvb_pkg::sat_smp(64'(wet[c])
                    + ((64'(ap_old[c]) + 64'sd1) >>> 1));
    end
  end

  // delay memories, registered read
  always_ff @(posedge clk) begin
    if (cmd.comb_rd) comb_rdata <= comb_mem[comb_addr];
    if (cmd.comb_wr) comb_mem[comb_addr] <= {comb_new[1], comb_new[0]};
  end

  always_ff @(posedge clk) begin
    if (cmd.ap_rd) ap_rdata <= ap_mem[ap_addr];
    if (cmd.ap_wr) ap_mem[ap_addr] <= {ap_new[1], ap_new[0]};
  end

  // pointers and wrap marks; an entry of a line that never wrapped reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < srvb_pkg::COMB_MAX; i++) comb_ptr[i] <= '0;
      for (int i = 0; i < srvb_pkg::AP_MAX; i++) ap_ptr[i] <= '0;
      comb_wrap   <= '0;
      ap_wrap     <= '0;
      comb_rvalid <= 1'b0;
      ap_rvalid   <= 1'b0;
    end else begin
      if (cmd.comb_rd) comb_rvalid <= comb_wrap[cmd.line];
      if (cmd.ap_rd) ap_rvalid <= ap_wrap[ap_line];
      if (cmd.comb_wr) begin
        if (comb_ptr[cmd.line] == srvb_pkg::CPW'(srvb_pkg::COMB_LEN[cmd.line] - 1)) begin
          comb_ptr[cmd.line]  <= '0;
          comb_wrap[cmd.line] <= 1'b1;
        end else begin
          comb_ptr[cmd.line] <= comb_ptr[cmd.line] + 1'b1;
        end
      end
      if (cmd.ap_wr) begin
        if (ap_ptr[ap_line] == srvb_pkg::APW'(srvb_pkg::AP_LEN[ap_line] - 1)) begin
          ap_ptr[ap_line]  <= '0;
          ap_wrap[ap_line] <= 1'b1;
        end else begin
          ap_ptr[ap_line] <= ap_ptr[ap_line] + 1'b1;
        end
      end
    end
  end

  // arithmetic registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      dry[0] <= $signed(in_data[SB-1:0]);
      dry[1] <= $signed(in_data[2*SB-1:SB]);
      wet[0] <= '0;
      wet[1] <= '0;
    end
    if (cmd.comb_mul) begin
      for (int c = 0; c < 2; c++) begin
        pc[c]  <= (SB + 17)'(comb_old[c]) * (SB + 17)'(fb_s);
        wet[c] <= wet[c] + srvb_pkg::WET_W'(comb_old[c]);
      end
    end
    if (cmd.ap_wr) begin
      for (int c = 0; c < 2; c++)
        wet[c] <= srvb_pkg::WET_W'(64'(ap_old[c]) - 64'(ap_new[c]));
    end
    if (cmd.gain) begin
      pw <= (srvb_pkg::WET_W + 18)'(wet[cmd.ch]) * (srvb_pkg::WET_W + 18)'(gw_s);
      pd <= (SB + 18)'(dry[cmd.ch]) * (SB + 18)'(gd_s);
    end
    if (cmd.mix) o[cmd.ch] <= srvb_pkg::O_W'((64'(pw) + 64'(pd) + 64'sd32768) >>> 16);
    if (cmd.wid_mul) begin
      msum <= (srvb_pkg::O_W + 1)'(o[0]) + (srvb_pkg::O_W + 1)'(o[1]);
      ws   <= (srvb_pkg::O_W + 19)'(wdiff) * (srvb_pkg::O_W + 19)'(w_s);
    end
    if (cmd.wid_fin) begin
      o[0] <= srvb_pkg::O_W'((mm - 64'(ws) + 64'sd65536) >>> 17);
      o[1] <= srvb_pkg::O_W'((mm + 64'(ws) + 64'sd65536) >>> 17);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load)
      out_data <= {srvb_pkg::sat_smp(64'(o[1])), srvb_pkg::sat_smp(64'(o[0]))};
  end

  assign stat.out_free     = !out_valid || out_ready;
  assign stat.width_bypass = (stereo_width == srvb_pkg::UNITY);

endmodule
`default_nettype wire

// ===== rtl/core/stereo_schroeder_reverb.sv =====
// top level of the stereo schroeder reverb: config registers, sequencer, datapath
//
// usage
//   s_* channel takes one stereo frame per item, m_* channel returns one frame.
//   cfg channel writes room_size, wet_gain, dry_gain, stereo_width (index 0..3);
//   cfg_ready is always high, writes to other indexes are dropped. write config
//   only while no item is in flight.
// sequence
//   an item walks a read, multiply and write step per comb line, a read and write
//   step per allpass line, a gain and a mix step per channel, then the two width
//   steps, which are skipped when stereo_width is unity, and the output step; the
//   next item is taken only once the sequencer is idle again. the sequencer walks
//   the delay lines one at a time through a single port of each delay memory.
//   s_tready is high only while the sequencer is idle.
// reset
//   rst clears the sequencer, line pointers and output valid. delay memories
//   are not swept: each line keeps a wrap mark, and entries of a line that has
//   not yet wrapped read as zero, so no clearing pass is needed.
// stall
//   the result waits in the output register; the next item is still accepted
//   and processed, and waits at its last step until the register frees up.
`default_nettype none
module stereo_schroeder_reverb #(
  parameter int COMB_LINES    = srvb_pkg::COMB_MAX,
  parameter int ALLPASS_LINES = srvb_pkg::AP_MAX
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [2*srvb_pkg::SB-1:0]         s_tdata,   // left_in, right_in
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [2*srvb_pkg::SB-1:0]              m_tdata,   // left_out, right_out
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [srvb_pkg::IDX_W-1:0]        cfg_index,
  input  wire logic [srvb_pkg::GAIN_W-1:0]       cfg_data
);

  srvb_pkg::srvb_cmd_t  cmd;
  srvb_pkg::srvb_stat_t stat;

  // config registers hold clamped gains; feedback is room_size * 0.9
  logic [srvb_pkg::FB_W-1:0]   fb;
  logic [srvb_pkg::GAIN_W-1:0] wet_gain, dry_gain, stereo_width;
  logic [srvb_pkg::GAIN_W-1:0] cfg_clamped;
  logic [19:0] room9;
  logic [39:0] room_prod;

  assign cfg_ready   = 1'b1;
  assign cfg_clamped = srvb_pkg::clamp_gain(cfg_data);
  // times nine as shift and add, then divide by ten with a reciprocal multiply
  assign room9       = {cfg_clamped, 3'b000} + 20'(cfg_clamped);
  assign room_prod   = 40'(room9) * 40'(srvb_pkg::DIV10_MUL);

  always_ff @(posedge clk) begin
    if (rst) begin
      fb           <= srvb_pkg::FB_RESET;
      wet_gain     <= srvb_pkg::WET_RESET;
      dry_gain     <= srvb_pkg::DRY_RESET;
      stereo_width <= srvb_pkg::WIDTH_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        srvb_pkg::REG_ROOM:  fb <= srvb_pkg::FB_W'(room_prod >> srvb_pkg::DIV10_SH);
        srvb_pkg::REG_WET:   wet_gain     <= cfg_clamped;
        srvb_pkg::REG_DRY:   dry_gain     <= cfg_clamped;
        srvb_pkg::REG_WIDTH: stereo_width <= cfg_clamped;
        default: ;
      endcase
    end
  end

  srvb_ctrl #(
    .COMB_LINES    (COMB_LINES),
    .ALLPASS_LINES (ALLPASS_LINES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  srvb_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .in_data      (s_tdata),
    .fb           (fb),
    .wet_gain     (wet_gain),
    .dry_gain     (dry_gain),
    .stereo_width (stereo_width),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_data     (m_tdata)
  );

  // an accepted item keeps the sequencer busy on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while item in flight");

  // no result is offered right after reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a result appears only after the sequencer loaded it
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.out_load))
    else $error("result without output load");

endmodule
`default_nettype wire
